@@ rtl/assert_macros.svh @@
// Assertion macros used by the serialiser of the address encoder.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ipb64_pkg.sv @@
// Types, constants and the digit alphabet of the base64 address encoder.
// No dependencies.
`default_nettype none

package ipb64_pkg;

  localparam int unsigned SegCount = 8;
  localparam int unsigned SegDigits = 3;
  localparam int unsigned SixDigits = 6;

  localparam logic [15:0] SIXTO4_PREFIX = 16'h2002;
  localparam logic [15:0] SEG_ALL_ONES  = 16'hFFFF;
  localparam logic [6:0]  CHAR_UNDERSCORE = 7'h5F;
  localparam logic [6:0]  CHAR_UPPER_A = 7'h41;
  localparam logic [6:0]  CHAR_LOWER_A = 7'h61;
  localparam logic [6:0]  CHAR_ZERO    = 7'h30;
  localparam logic [6:0]  CHAR_LBRACK  = 7'h5B;
  localparam logic [6:0]  CHAR_RBRACK  = 7'h5D;

  typedef struct packed {
    logic [15:0] segment_0;
    logic [15:0] segment_1;
    logic [15:0] segment_2;
    logic [15:0] segment_3;
    logic [15:0] segment_4;
    logic [15:0] segment_5;
    logic [15:0] segment_6;
    logic [15:0] segment_7;
    logic        peer_accepts_v6;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       last_char;
  } out_beat_t;

  // after classification
  typedef struct packed {
    logic [SegCount-1:0][15:0] seg;
    logic                      v6;
    logic [31:0]               six_val;
    logic                      has_run;
    logic [2:0]                run_start;
    logic [3:0]                run_len;
  } cls_t;

  // after digit expansion
  typedef struct packed {
    logic [SegCount-1:0][SegDigits-1:0][6:0] seg_chars;
    logic [SixDigits-1:0][6:0]               six_chars;
    logic                                    v6;
    logic                                    has_run;
    logic [2:0]                              run_start;
    logic [3:0]                              run_end;
  } exp_t;

  function automatic logic [6:0] b64_char(input logic [5:0] d);
    logic [6:0] dd;
    dd = {1'b0, d};
    if (d < 6'd26) begin
      return CHAR_UPPER_A + dd;
    end else if (d < 6'd52) begin
      return CHAR_LOWER_A + dd - 7'd26;
    end else if (d < 6'd62) begin
      return CHAR_ZERO + dd - 7'd52;
    end else if (d == 6'd62) begin
      return CHAR_LBRACK;
    end else begin
      return CHAR_RBRACK;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/ipb64_classify.sv @@
// Classification stage: address kind and longest zero-segment run.
// Depends on ipb64_pkg.
`default_nettype none

module ipb64_classify (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  ipb64_pkg::in_beat_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output ipb64_pkg::cls_t    dn_data
);
  import ipb64_pkg::*;

  logic                      v_r;
  cls_t                      d_r;
  cls_t                      d_nxt;
  logic [SegCount-1:0][15:0] seg;
  logic [SegCount-1:0]       zero;

  assign seg[0] = up_data.segment_0;
  assign seg[1] = up_data.segment_1;
  assign seg[2] = up_data.segment_2;
  assign seg[3] = up_data.segment_3;
  assign seg[4] = up_data.segment_4;
  assign seg[5] = up_data.segment_5;
  assign seg[6] = up_data.segment_6;
  assign seg[7] = up_data.segment_7;

  always_comb begin
    for (int i = 0; i < SegCount; i++) begin
      zero[i] = (seg[i] == 16'd0);
    end
  end

  always_comb begin
    logic       is_v4;
    logic [3:0] cur;
    logic [3:0] best_len;
    logic [2:0] best_start;
    logic [3:0] tmp;
    is_v4 = zero[0] && zero[1] && zero[2] && zero[3] && zero[4] &&
            ((zero[5] && !zero[6]) || (seg[5] == SEG_ALL_ONES));
    cur = 4'd0;
    best_len = 4'd0;
    best_start = 3'd0;
    tmp = 4'd0;
    for (int i = 0; i < SegCount; i++) begin
      if (zero[i]) begin
        cur = cur + 4'd1;
        if (cur > best_len) begin
          best_len = cur;
          tmp = 4'(i + 1) - cur;
          best_start = tmp[2:0];
        end
      end else begin
        cur = 4'd0;
      end
    end
    d_nxt.seg = seg;
    d_nxt.has_run = (best_len != 4'd0);
    d_nxt.run_start = best_start;
    d_nxt.run_len = best_len;
    if (is_v4) begin
      d_nxt.v6 = 1'b0;
      d_nxt.six_val = {seg[6], seg[7]};
    end else if (!up_data.peer_accepts_v6) begin
      d_nxt.v6 = 1'b0;
      d_nxt.six_val = (seg[0] == SIXTO4_PREFIX) ? {seg[1], seg[2]} : 32'd0;
    end else begin
      d_nxt.v6 = 1'b1;
      d_nxt.six_val = 32'd0;
    end
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

`default_nettype wire

@@ rtl/ipb64_expand.sv @@
// Expansion stage: every 6-bit digit turned into its ASCII character.
// Depends on ipb64_pkg.
`default_nettype none

module ipb64_expand (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  ipb64_pkg::cls_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output ipb64_pkg::exp_t dn_data
);
  import ipb64_pkg::*;

  logic v_r;
  exp_t d_r;
  exp_t d_nxt;

  always_comb begin
    logic [17:0] ext;
    logic [35:0] wide;
    for (int i = 0; i < SegCount; i++) begin
      ext = {2'b00, up_data.seg[i]};
      for (int k = 0; k < SegDigits; k++) begin
        d_nxt.seg_chars[i][k] = b64_char(ext[17 - 6*k -: 6]);
      end
    end
    wide = {4'd0, up_data.six_val};
    for (int k = 0; k < SixDigits; k++) begin
      d_nxt.six_chars[k] = b64_char(wide[35 - 6*k -: 6]);
    end
    d_nxt.v6 = up_data.v6;
    d_nxt.has_run = up_data.has_run;
    d_nxt.run_start = up_data.run_start;
    d_nxt.run_end = {1'b0, up_data.run_start} + up_data.run_len;
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

`default_nettype wire

@@ rtl/ipb64_serial.sv @@
// Serialiser: walks one expanded address, one character beat per cycle.
// Depends on ipb64_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ipb64_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  ipb64_pkg::exp_t      up_data,
  output logic                 out_valid,
  output ipb64_pkg::out_beat_t out_data
);
  import ipb64_pkg::*;

  logic       ser_v_r;
  logic       ser_v_nxt;
  exp_t       ser_r;
  logic [2:0] idx_r;
  logic [2:0] idx_nxt;
  logic [1:0] dig_r;
  logic [1:0] dig_nxt;
  logic [2:0] idx_step;
  logic [1:0] dig_step;
  logic [6:0] ch;
  logic       last;
  logic       out_valid_r;
  out_beat_t  out_r;

  always_comb begin
    ch = CHAR_UNDERSCORE;
    last = 1'b0;
    idx_step = idx_r + 3'd1;
    dig_step = 2'd0;
    if (!ser_r.v6) begin
      ch = ser_r.six_chars[idx_r];
      last = (idx_r == 3'(SixDigits - 1));
    end else if (ser_r.has_run && (idx_r == ser_r.run_start)) begin
      ch = CHAR_UNDERSCORE;
      last = ser_r.run_end[3];
      idx_step = ser_r.run_end[2:0];
    end else begin
      ch = ser_r.seg_chars[idx_r][dig_r];
      if (dig_r == 2'(SegDigits - 1)) begin
        last = (idx_r == 3'(SegCount - 1));
      end else begin
        idx_step = idx_r;
        dig_step = dig_r + 2'd1;
      end
    end
  end

  assign up_ready = !ser_v_r || last;

  always_comb begin
    ser_v_nxt = ser_v_r;
    idx_nxt = idx_step;
    dig_nxt = dig_step;
    if (up_ready) begin
      ser_v_nxt = up_valid;
      idx_nxt = 3'd0;
      dig_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ser_v_r <= ser_v_nxt;
      out_valid_r <= ser_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ser_r <= up_data;
    end
    if (ser_v_r) begin
      idx_r <= idx_nxt;
      dig_r <= dig_nxt;
    end else begin
      idx_r <= 3'd0;
      dig_r <= 2'd0;
    end
    out_r.char_out <= ch;
    out_r.last_char <= last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_NEXT(a_out_follows, ser_v_r, out_valid)
  `ASSERT_NEXT(a_no_gap, ser_v_r && !last, ser_v_r)
  `ASSERT_IMPL(a_char_legal, out_valid,
    (out_data.char_out >= 7'h41 && out_data.char_out <= 7'h5A) ||
    (out_data.char_out >= 7'h61 && out_data.char_out <= 7'h7A) ||
    (out_data.char_out >= 7'h30 && out_data.char_out <= 7'h39) ||
    out_data.char_out == CHAR_LBRACK || out_data.char_out == CHAR_RBRACK ||
    out_data.char_out == CHAR_UNDERSCORE)

endmodule

`default_nettype wire

@@ rtl/ip_address_base64_encoder.sv @@
// First character path: input, classify, expand, serialiser and output registers.
// Throughput: one character per cycle; an address holds the serialiser until all its
// characters (1 to 24) are out, and busy rises once the stages behind it fill.
// Output strobe is unconditional: the receiver cannot stall.
// Reset: synchronous, active low; clears all valid bits, no characters pending.
`default_nettype none

module ip_address_base64_encoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ipb64_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  output ipb64_pkg::out_beat_t out_data
);
  import ipb64_pkg::*;

  logic     s1_v_r;
  in_beat_t s1_r;
  logic     s1_ready;
  logic     cls_ready;
  logic     cls_valid;
  cls_t     cls_data;
  logic     exp_ready;
  logic     exp_valid;
  exp_t     exp_data;
  logic     ser_ready;

  assign s1_ready = !s1_v_r || cls_ready;
  assign busy = !s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && start) begin
      s1_r <= in_data;
    end
  end

  ipb64_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_v_r),
    .up_ready (cls_ready),
    .up_data  (s1_r),
    .dn_valid (cls_valid),
    .dn_ready (exp_ready),
    .dn_data  (cls_data)
  );

  ipb64_expand u_expand (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (cls_valid),
    .up_ready (exp_ready),
    .up_data  (cls_data),
    .dn_valid (exp_valid),
    .dn_ready (ser_ready),
    .dn_data  (exp_data)
  );

  ipb64_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (exp_valid),
    .up_ready  (ser_ready),
    .up_data   (exp_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
